>>> hw/rtl/sdhb_pkg.sv
// Shared types and constants for the session deframer with heartbeat.
// Holds the framing bytes, phase encoding, event codes and register defaults.
// No dependencies.
package sdhb_pkg;

    localparam logic [7:0] SOH_BYTE = 8'h01;
    localparam logic [7:0] STX_BYTE = 8'h02;
    localparam logic [7:0] ETX_BYTE = 8'h03;
    localparam logic [7:0] ETB_BYTE = 8'h17;

    // Header and trailer are six bytes each; the size field counts the trailer.
    localparam logic [31:0] FRAME_EDGE = 32'd6;

    localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd1048576;
    localparam logic [15:0] TIMEOUT_RESET     = 16'd0;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PAYLOAD = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT     = 1'd1;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_BODY   = 4'b0010,
        PH_HALTED = 4'b0100,
        PH_CLOSED = 4'b1000
    } phase_t;

    typedef enum logic [2:0] {
        EV_CONTENT  = 3'd0,
        EV_DONE     = 3'd1,
        EV_OVERSIZE = 3'd2,
        EV_SHORT    = 3'd3,
        EV_TIMEOUT  = 3'd4,
        EV_SYNC     = 3'd5
    } event_t;

    typedef struct packed {
        logic [31:0] content_length;
        logic [31:0] message_id;
        logic [7:0]  content_byte;
    } result_t;

endpackage

>>> hw/rtl/session_deframer_with_heartbeat_unit.sv
// Top level of the session deframer with heartbeat.
// Parses framed bytes, emits content and message events, runs the heartbeat.
// Depends on sdhb_pkg.
//
// Usage: each request on the s_ channel is either one received byte
// (s_tuser low) or one second tick (s_tuser high), with the login flag
// beside the byte in s_tdata. Each request yields zero or one result on the
// m_ channel: a content byte, a finished message (id and content length),
// or a terminal event (closed oversize, closed short, closed timeout,
// halted on bad sync). Registers are written through cfg_we/cfg_index/
// cfg_data while the block is idle.
// The result of a request is registered and shown on m_tvalid after the
// edge that accepts it. Throughput is one request per cycle unless the
// receiver stalls; the whole parse step is a few compares and one counter
// update that sit between the state registers and the result register.
// Reset (aresetn low, synchronous) returns the parser to the header phase,
// sets the alive mark, clears the tick count and the result valid flag, and
// loads the register defaults (1 MiB payload limit, heartbeat off).
// When the receiver stalls, the pending result holds in the output register
// and s_tready drops; a new request is taken in the same cycle that the
// pending result is taken.
module session_deframer_with_heartbeat_unit
    import sdhb_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // Configuration write port.
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // Request channel.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [15:0]            s_tdata,   // [7:0] rx_byte, [8] logged_in, rest zero
    input  logic                   s_tuser,   // [0] command
    // Result channel.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [71:0]            m_tdata,   // [7:0] content_byte, [39:8] message_id,
                                              // [71:40] content_length
    output logic [2:0]             m_tuser    // [2:0] event_res
);

    // Configuration registers.
    logic [31:0] max_payload_reg;
    logic [15:0] timeout_reg;

    // Parser and heartbeat state.
    phase_t      phase_reg, phase_next;
    logic [31:0] byte_index_reg, byte_index_next;
    logic [31:0] payload_size_reg, payload_size_next;
    logic [7:0]  first_byte_reg, first_byte_next;
    logic [39:0] trailer_reg, trailer_next;
    logic        alive_reg, alive_next;
    logic [15:0] tick_count_reg, tick_count_next;
    // Frame bounds derived once per header so the body compares stay short.
    logic [31:0] content_len_reg, content_len_next;
    logic [31:0] last_index_reg, last_index_next;

    // Output register.
    logic        m_valid_reg;
    result_t     m_data_reg;
    event_t      m_event_reg;

    logic        s_accept;
    logic        cmd;
    logic [7:0]  rx_byte;
    logic        logged_in;

    logic        res_valid;
    event_t      res_event;
    result_t     res_data;

    logic [15:0] tick_inc;
    logic [31:0] full_size;

    assign cmd       = s_tuser;
    assign rx_byte   = s_tdata[7:0];
    assign logged_in = s_tdata[8];

    // A new request is taken whenever the output register is free or drains now.
    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    assign tick_inc = tick_count_reg + 16'd1;

    // The size as it stands once the fifth header byte has been folded in.
    assign full_size = payload_size_reg;

    always_comb begin
        phase_next        = phase_reg;
        byte_index_next   = byte_index_reg;
        payload_size_next = payload_size_reg;
        first_byte_next   = first_byte_reg;
        trailer_next      = trailer_reg;
        alive_next        = alive_reg;
        tick_count_next   = tick_count_reg;
        content_len_next  = content_len_reg;
        last_index_next   = last_index_reg;
        res_valid         = 1'b0;
        res_event         = EV_CONTENT;
        res_data          = '0;

        if (phase_reg == PH_CLOSED) begin
            // A closed session ignores everything until reset.
        end else if (cmd == CMD_TICK) begin
            // Heartbeat: a zero period leaves the counter untouched.
            if (timeout_reg != 16'd0) begin
                if (tick_inc < timeout_reg) begin
                    tick_count_next = tick_inc;
                end else begin
                    tick_count_next = 16'd0;
                    if (alive_reg && logged_in) begin
                        alive_next = 1'b0;
                    end else begin
                        phase_next = PH_CLOSED;
                        res_valid  = 1'b1;
                        res_event  = EV_TIMEOUT;
                    end
                end
            end
        end else begin
            case (phase_reg)
                PH_HEADER: begin
                    if (byte_index_reg == 32'd0) begin
                        first_byte_next   = rx_byte;
                        payload_size_next = 32'd0;
                        byte_index_next   = 32'd1;
                    end else if (byte_index_reg < 32'd5) begin
                        // Size arrives least significant byte first.
                        case (byte_index_reg[2:0])
                            3'd1:    payload_size_next[7:0]   = rx_byte;
                            3'd2:    payload_size_next[15:8]  = rx_byte;
                            3'd3:    payload_size_next[23:16] = rx_byte;
                            3'd4:    payload_size_next[31:24] = rx_byte;
                            default: payload_size_next        = payload_size_reg;
                        endcase
                        byte_index_next = byte_index_reg + 32'd1;
                    end else begin
                        byte_index_next  = 32'd0;
                        content_len_next = full_size - FRAME_EDGE;
                        last_index_next  = full_size - 32'd1;
                        if (first_byte_reg != SOH_BYTE || rx_byte != STX_BYTE) begin
                            phase_next = PH_HALTED;
                            res_valid  = 1'b1;
                            res_event  = EV_SYNC;
                        end else if (full_size > max_payload_reg) begin
                            phase_next = PH_CLOSED;
                            res_valid  = 1'b1;
                            res_event  = EV_OVERSIZE;
                        end else if (full_size < FRAME_EDGE) begin
                            phase_next = PH_CLOSED;
                            res_valid  = 1'b1;
                            res_event  = EV_SHORT;
                        end else begin
                            phase_next   = PH_BODY;
                            alive_next   = 1'b1;
                            trailer_next = 40'd0;
                        end
                    end
                end
                PH_BODY: begin
                    if (byte_index_reg < content_len_reg) begin
                        byte_index_next       = byte_index_reg + 32'd1;
                        res_valid             = 1'b1;
                        res_event             = EV_CONTENT;
                        res_data.content_byte = rx_byte;
                    end else if (byte_index_reg < last_index_reg) begin
                        // First five trailer bytes: ETX and the id.
                        trailer_next    = {trailer_reg[31:0], rx_byte};
                        byte_index_next = byte_index_reg + 32'd1;
                    end else begin
                        phase_next      = PH_HEADER;
                        byte_index_next = 32'd0;
                        // A bad trailer drops the frame with no result.
                        if (trailer_reg[39:32] == ETX_BYTE && rx_byte == ETB_BYTE) begin
                            res_valid               = 1'b1;
                            res_event               = EV_DONE;
                            res_data.message_id     = {trailer_reg[7:0], trailer_reg[15:8],
                                                       trailer_reg[23:16], trailer_reg[31:24]};
                            res_data.content_length = content_len_reg;
                        end
                    end
                end
                default: begin
                    // Halted: bytes are ignored, ticks are handled above.
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_payload_reg <= MAX_PAYLOAD_RESET;
            timeout_reg     <= TIMEOUT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MAX_PAYLOAD: max_payload_reg <= cfg_data;
                CFG_TIMEOUT:     timeout_reg     <= cfg_data[15:0];
                default:         max_payload_reg <= max_payload_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_HEADER;
            byte_index_reg   <= 32'd0;
            payload_size_reg <= 32'd0;
            first_byte_reg   <= 8'd0;
            trailer_reg      <= 40'd0;
            alive_reg        <= 1'b1;
            tick_count_reg   <= 16'd0;
            content_len_reg  <= 32'd0;
            last_index_reg   <= 32'd0;
        end else if (s_accept) begin
            phase_reg        <= phase_next;
            byte_index_reg   <= byte_index_next;
            payload_size_reg <= payload_size_next;
            first_byte_reg   <= first_byte_next;
            trailer_reg      <= trailer_next;
            alive_reg        <= alive_next;
            tick_count_reg   <= tick_count_next;
            content_len_reg  <= content_len_next;
            last_index_reg   <= last_index_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept && res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && res_valid) begin
            m_data_reg  <= res_data;
            m_event_reg <= res_event;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_event_reg;

endmodule

>>> tb/session_deframer_with_heartbeat_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for session_deframer_with_heartbeat_unit.
// Drives framed bytes and second ticks, predicts every result and checks it.
// Depends on sdhb_pkg and the RTL of the block.
module session_deframer_with_heartbeat_unit_tb;
    import sdhb_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 40;
    localparam int LATENCY_PAD  = 4;
    localparam int MAX_BODY     = 24;

    // One request as the sender sees it.
    typedef struct {
        logic       cmd;
        logic [7:0] data;
        logic       logged;
    } req_t;

    // One expected result, laid out like the m_ channel.
    typedef struct {
        event_t      ev;
        logic [7:0]  cb;
        logic [31:0] id;
        logic [31:0] len;
    } outcome_t;

    // Our own copy of the parser, the heartbeat and both registers.
    typedef struct {
        phase_t      ph;
        logic [31:0] idx;
        logic [31:0] psize;
        logic [7:0]  first;
        logic [39:0] trl;
        logic        alive;
        logic [15:0] ticks;
        logic [31:0] max_pl;
        logic [15:0] period;
    } sess_t;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_MAX_PAYLOAD;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [15:0]            s_tdata   = '0;   // [7:0] rx_byte, [8] logged_in, rest zero
    logic                   s_tuser   = 1'b0; // [0] command
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [71:0]            m_tdata;          // [7:0] content_byte, [39:8] message_id,
                                              // [71:40] content_length
    logic [2:0]             m_tuser;          // [2:0] event_res

    sess_t    sess;
    outcome_t expected_q[$];
    int       errors        = 0;
    int       reqs_sent     = 0;
    int       results_seen  = 0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    int       tick_pct      = 0;
    bit       allow_end     = 1'b0;
    int       hold_asked    = 0;
    int       hold_done     = 0;
    int       hold_left     = 0;
    int       cycles        = 0;
    string    ending        = "no";

    session_deframer_with_heartbeat_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Watchdog: a run that hangs on a handshake or loses a result ends here.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: watchdog expired with %0d results outstanding", $time,
                     expected_q.size());
            $display("session_deframer_with_heartbeat_unit verification failed");
            $finish;
        end
    end

    // Advances the session by one request. Returns 1 when the request yields a
    // result, which is then left in o. Written from the framing rules: the size
    // field counts content plus the six trailer bytes, and the id is sent with
    // its least significant byte first.
    function automatic bit deframe_step(inout sess_t s, input req_t r, output outcome_t o);
        logic [31:0] content;
        o = '{ev: EV_CONTENT, cb: 8'h00, id: 32'h0, len: 32'h0};
        if (s.ph == PH_CLOSED) return 1'b0;
        if (r.cmd == CMD_TICK) begin
            // With the heartbeat off the tick count is frozen, not cleared.
            if (s.period == 16'd0) return 1'b0;
            s.ticks = s.ticks + 16'd1;
            // A period also ends when the count already passed a lowered period.
            if (s.ticks < s.period) return 1'b0;
            s.ticks = 16'd0;
            if (s.alive && r.logged) begin
                s.alive = 1'b0;
                return 1'b0;
            end
            s.ph = PH_CLOSED;
            o.ev = EV_TIMEOUT;
            return 1'b1;
        end
        if (s.ph == PH_HEADER) begin
            if (s.idx == 32'd0) begin
                s.first = r.data;
                s.psize = 32'd0;
                s.idx   = 32'd1;
                return 1'b0;
            end
            if (s.idx < 32'd5) begin
                s.psize = s.psize | ({24'h0, r.data} << (8 * (s.idx - 32'd1)));
                s.idx   = s.idx + 32'd1;
                return 1'b0;
            end
            s.idx = 32'd0;
            if (s.first != SOH_BYTE || r.data != STX_BYTE) begin
                s.ph = PH_HALTED;
                o.ev = EV_SYNC;
                return 1'b1;
            end
            // The size limit is checked before the lower bound.
            if (s.psize > s.max_pl) begin
                s.ph = PH_CLOSED;
                o.ev = EV_OVERSIZE;
                return 1'b1;
            end
            if (s.psize < FRAME_EDGE) begin
                s.ph = PH_CLOSED;
                o.ev = EV_SHORT;
                return 1'b1;
            end
            s.ph    = PH_BODY;
            s.alive = 1'b1;
            s.trl   = 40'h0;
            return 1'b0;
        end
        if (s.ph == PH_BODY) begin
            content = s.psize - FRAME_EDGE;
            if (s.idx < content) begin
                s.idx = s.idx + 32'd1;
                o.cb  = r.data;
                return 1'b1;
            end
            if (s.idx + 32'd1 < s.psize) begin
                s.trl = {s.trl[31:0], r.data};
                s.idx = s.idx + 32'd1;
                return 1'b0;
            end
            // Last trailer byte: a bad ETX or ETB silently drops the frame.
            s.ph  = PH_HEADER;
            s.idx = 32'd0;
            if (s.trl[39:32] != ETX_BYTE || r.data != ETB_BYTE) return 1'b0;
            o.ev  = EV_DONE;
            o.id  = {s.trl[7:0], s.trl[15:8], s.trl[23:16], s.trl[31:24]};
            o.len = content;
            return 1'b1;
        end
        // Halted: bytes are ignored.
        return 1'b0;
    endfunction

    // Receiver and checker. Each accepted result is compared with the oldest
    // expectation. The receiver idles at random, and on request from a test it
    // holds m_tready low for a long stretch that it counts itself.
    always @(posedge aclk) begin : result_side
        outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected: event %0d data %h", $time,
                         m_tuser, m_tdata);
            end else begin
                want = expected_q.pop_front();
                if (m_tuser !== want.ev) begin
                    errors++;
                    $display("%0t: event expected %0d actual %0d", $time, want.ev, m_tuser);
                end
                if (m_tdata[7:0] !== want.cb) begin
                    errors++;
                    $display("%0t: content_byte expected %h actual %h", $time, want.cb,
                             m_tdata[7:0]);
                end
                if (m_tdata[39:8] !== want.id) begin
                    errors++;
                    $display("%0t: message_id expected %h actual %h", $time, want.id,
                             m_tdata[39:8]);
                end
                if (m_tdata[71:40] !== want.len) begin
                    errors++;
                    $display("%0t: content_length expected %0d actual %0d", $time, want.len,
                             m_tdata[71:40]);
                end
            end
        end
        if (hold_left == 0 && hold_done != hold_asked) begin
            hold_left = HOLD_CYCLES;
            hold_done = hold_asked;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Offers one request, waits for its handshake and then records what it
    // should produce. s_tvalid is only lowered for an idle gap, so back-to-back
    // requests never see it lowered and raised in the same step.
    task automatic send_req(input req_t r);
        outcome_t o;
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, r.logged, r.data};
        s_tuser  <= r.cmd;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (deframe_step(sess, r, o)) expected_q.push_back(o);
        reqs_sent++;
        // Each cycle is idle with the set chance, so the sender is off for that share.
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    // A tick that would close the session is turned into a logged-in tick, or
    // left out when the alive mark is already clear, unless a test wants the end.
    task automatic send_tick(input logic logged);
        sess_t    trial;
        outcome_t o;
        req_t     r;
        r.cmd    = CMD_TICK;
        r.data   = 8'($urandom_range(0, 255));
        r.logged = logged;
        if (!allow_end) begin
            trial = sess;
            if (deframe_step(trial, r, o) && o.ev == EV_TIMEOUT) begin
                r.logged = 1'b1;
                trial    = sess;
                if (deframe_step(trial, r, o)) return;
            end
        end
        send_req(r);
    endtask

    // One received byte, sometimes preceded by a tick.
    task automatic send_byte(input logic [7:0] b);
        req_t r;
        if ($urandom_range(0, 99) < tick_pct) send_tick($urandom_range(0, 3) != 0);
        r.cmd    = CMD_BYTE;
        r.data   = b;
        r.logged = 1'($urandom_range(0, 1));
        send_req(r);
    endtask

    task automatic send_header(input logic [7:0] sof, input logic [31:0] psize,
                               input logic [7:0] eoh);
        send_byte(sof);
        for (int k = 0; k < 4; k++) send_byte(psize[8*k +: 8]);
        send_byte(eoh);
    endtask

    task automatic send_frame(input logic [7:0] body[$], input logic [31:0] id,
                              input logic [7:0] etx, input logic [7:0] etb);
        send_header(SOH_BYTE, body.size() + FRAME_EDGE, STX_BYTE);
        foreach (body[i]) send_byte(body[i]);
        send_byte(etx);
        for (int k = 0; k < 4; k++) send_byte(id[8*k +: 8]);
        send_byte(etb);
    endtask

    // The sender stops, every outstanding result is taken, and a few more
    // cycles pass since a request that yields nothing may still be in flight.
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (LATENCY_PAD) @(posedge aclk);
    endtask

    // Writes the payload limit, then the timeout register. The upper half of the
    // timeout write carries junk, which the block must drop.
    task automatic write_regs(input logic [31:0] max_pl, input logic [15:0] tmo);
        logic [15:0] junk;
        junk      = 16'($urandom_range(0, 65535));
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MAX_PAYLOAD;
        cfg_data  <= max_pl;
        @(posedge aclk);
        cfg_index <= CFG_TIMEOUT;
        cfg_data  <= {junk, tmo};
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sess.max_pl = max_pl;
        sess.period = tmo;
    endtask

    // Register defaults: a two-byte frame with the extreme content values and
    // an all-ones id, a tick while the heartbeat is off, and an empty frame
    // whose ETB is wrong.
    task automatic test_frame_basics();
        logic [7:0] body[$];
        tick_pct = 0;
        body.push_back(8'h00);
        body.push_back(8'hFF);
        send_frame(body, 32'hFFFF_FFFF, ETX_BYTE, ETB_BYTE);
        send_tick(1'b0);
        body.delete();
        send_frame(body, 32'h0000_0000, ETX_BYTE, 8'h00);
    endtask

    // Heartbeat edges: the widest period with ticks counted while logged out,
    // then a period lowered below the count so the next tick ends it, then the
    // heartbeat switched off with the count held.
    task automatic test_heartbeat_period();
        logic [7:0] body[$];
        wait_results_drained();
        write_regs(MAX_PAYLOAD_RESET, 16'hFFFF);
        repeat (3) send_tick(1'b0);
        wait_results_drained();
        write_regs(MAX_PAYLOAD_RESET, 16'd2);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b1);
        body.push_back(8'h5A);
        send_frame(body, 32'h1234_5678, ETX_BYTE, ETB_BYTE);
        wait_results_drained();
        write_regs(MAX_PAYLOAD_RESET, TIMEOUT_RESET);
        send_tick(1'b0);
        send_tick(1'b1);
    endtask

    // Random frames: mostly well formed with random content and ids, some
    // with a broken ETX or ETB, and ticks scattered through every phase.
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input logic [31:0] max_pl, input logic [15:0] tmo,
                                       input int n_reqs);
        logic [7:0]  body[$];
        logic [7:0]  etx;
        logic [7:0]  etb;
        logic [31:0] cap;
        int          start;
        int          kind;
        wait_results_drained();
        write_regs(max_pl, tmo);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        tick_pct      = 6;
        start         = reqs_sent;
        cap = (max_pl - FRAME_EDGE > MAX_BODY) ? MAX_BODY : max_pl - FRAME_EDGE;
        while (reqs_sent - start < n_reqs) begin
            body.delete();
            repeat ($urandom_range(0, cap)) body.push_back(8'($urandom_range(0, 255)));
            etx  = ETX_BYTE;
            etb  = ETB_BYTE;
            kind = $urandom_range(0, 99);
            if (kind < 8) begin
                do etx = 8'($urandom_range(0, 255)); while (etx == ETX_BYTE);
            end else if (kind < 16) begin
                do etb = 8'($urandom_range(0, 255)); while (etb == ETB_BYTE);
            end
            send_frame(body, $urandom, etx, etb);
        end
    endtask

    // The receiver stops for a long stretch while a long frame keeps coming,
    // so the result register fills and the block must stall its input.
    task automatic test_receiver_holdoff();
        logic [7:0] body[$];
        wait_results_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        tick_pct      = 0;
        repeat (20) body.push_back(8'($urandom_range(0, 255)));
        hold_asked++;
        send_frame(body, $urandom, ETX_BYTE, ETB_BYTE);
    endtask

    // The session can end only once per reset, so one ending is picked at
    // random: oversize, short size, bad sync followed by a timeout, or a
    // timeout on a cleared alive mark. Later requests must all be ignored.
    task automatic test_session_end();
        logic [31:0] psize;
        logic [31:0] lim;
        logic [7:0]  bad;
        int          pick;
        wait_results_drained();
        allow_end     = 1'b1;
        tick_pct      = 0;
        send_idle_pct = 20;
        recv_idle_pct = 20;
        pick          = $urandom_range(0, 3);
        case (pick)
            0: begin
                ending = "oversize";
                lim = ($urandom_range(0, 1) != 0) ? 32'd0 : $urandom_range(6, 100);
                write_regs(lim, TIMEOUT_RESET);
                psize = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF
                                                    : lim + 32'd1 + $urandom_range(0, 1000);
                send_header(SOH_BYTE, psize, STX_BYTE);
            end
            1: begin
                ending = "short size";
                send_header(SOH_BYTE, $urandom_range(0, 5), STX_BYTE);
            end
            2: begin
                ending = "bad sync then timeout";
                if ($urandom_range(0, 1) != 0) begin
                    do bad = 8'($urandom_range(0, 255)); while (bad == SOH_BYTE);
                    send_header(bad, $urandom, STX_BYTE);
                end else begin
                    do bad = 8'($urandom_range(0, 255)); while (bad == STX_BYTE);
                    send_header(SOH_BYTE, $urandom, bad);
                end
                // Halted: bytes, even a good header, are dropped.
                send_header(SOH_BYTE, 32'd10, STX_BYTE);
                wait_results_drained();
                write_regs(sess.max_pl, 16'd1);
                send_tick(1'b0);
            end
            default: begin
                ending = "heartbeat timeout";
                write_regs(sess.max_pl, 16'd1);
                while (sess.ph != PH_CLOSED) send_tick(1'b1);
            end
        endcase
        repeat (8) begin
            if ($urandom_range(0, 1) != 0) send_tick(1'($urandom_range(0, 1)));
            else send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        sess = '{ph: PH_HEADER, idx: 32'd0, psize: 32'd0, first: 8'h00, trl: 40'h0,
                 alive: 1'b1, ticks: 16'd0, max_pl: MAX_PAYLOAD_RESET,
                 period: TIMEOUT_RESET};
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 32;
        recv_idle_pct = 46;
        test_frame_basics();
        test_heartbeat_period();
        test_random_traffic(32, 46, 32'hFFFF_FFFF, 16'($urandom_range(1, 4)), 450);
        test_random_traffic(46, 32, FRAME_EDGE + $urandom_range(0, 12),
                            16'($urandom_range(2, 10)), 450);
        test_random_traffic(0, 0, $urandom_range(20, 60), TIMEOUT_RESET, 450);
        test_receiver_holdoff();
        test_session_end();
        wait_results_drained();

        $display("Sent %0d requests and checked %0d results over framing, broken trailers,",
                 reqs_sent, results_seen);
        $display("heartbeat periods, stalls on both sides and a %s ending.", ending);
        if (errors == 0) begin
            $display("session_deframer_with_heartbeat_unit verification clean");
        end else begin
            $display("session_deframer_with_heartbeat_unit verification failed");
        end
        $finish;
    end

endmodule
